@@ src/fqs_pkg.sv @@
`default_nettype none

package fqs_pkg;

    // Item kinds on the input channel
    typedef enum logic {
        OP_ARRIVAL = 1'b0,
        OP_TICK    = 1'b1
    } t_opcode;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FEEDBACK_MODE = 2'd0,
        CFG_SLICE_ONE     = 2'd1,
        CFG_SLICE_TWO     = 2'd2,
        CFG_SLICE_THREE   = 2'd3
    } t_cfg_index;

    // Queue levels
    localparam int NUM_LEVELS = 3;
    localparam int LEVEL_BITS = 2;

    typedef enum logic [LEVEL_BITS-1:0] {
        LEVEL_ONE   = 2'd0,
        LEVEL_TWO   = 2'd1,
        LEVEL_THREE = 2'd2
    } t_level;

    localparam int SLICE_BITS = 8;

    localparam logic                  RST_FEEDBACK_MODE = 1'b1;
    localparam logic [SLICE_BITS-1:0] RST_SLICE_ONE     = 8'd2;
    localparam logic [SLICE_BITS-1:0] RST_SLICE_TWO     = 8'd4;
    localparam logic [SLICE_BITS-1:0] RST_SLICE_THREE   = 8'd8;

    // Requests from the scheduler to one level queue
    typedef struct packed {
        logic push;
        logic pop;
    } t_lvl_req;

    // Status of one level queue
    typedef struct packed {
        logic empty;
        logic full;
    } t_lvl_sts;

    // A programmed slice of zero behaves as one tick
    function automatic logic [SLICE_BITS-1:0] eff_slice(input logic [SLICE_BITS-1:0] s);
        eff_slice = (s == '0) ? SLICE_BITS'(1) : s;
    endfunction

endpackage

`default_nettype wire

@@ src/fqs_if.sv @@
`default_nettype none

// Input item channel
interface fqs_in_if #(
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [ID_BITS-1:0]   process_id;
    logic [TIME_BITS-1:0] run_time;

    modport source (output valid, output opcode, output process_id, output run_time,
                    input ready);
    modport sink   (input valid, input opcode, input process_id, input run_time,
                    output ready);
endinterface

// Result channel
interface fqs_out_if #(
    parameter int ID_BITS = 16
);
    logic               valid;
    logic               ready;
    logic               busy_res;
    logic [ID_BITS-1:0] running_id;
    logic               dispatched;
    logic               finished;
    logic               dropped;

    modport source (output valid, output busy_res, output running_id, output dispatched,
                    output finished, output dropped, input ready);
    modport sink   (input valid, input busy_res, input running_id, input dispatched,
                    input finished, input dropped, output ready);
endinterface

// Configuration write channel
interface fqs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [fqs_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [fqs_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/fqs_ram.sv @@
`default_nettype none

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, registered read port (old data on a same-address collision)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ src/fqs_level.sv @@
`default_nettype none

// One circular level queue: RAM storage plus a head entry that is always
// ready to pop in the same cycle. The RAM is read at the next head pointer,
// and a write landing on that slot is forwarded through a bypass register.
module fqs_level #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fqs_pkg::t_lvl_req i_req,
    input  wire logic [WIDTH-1:0]  i_push_data,
    output fqs_pkg::t_lvl_sts      o_sts,
    output logic      [WIDTH-1:0]  o_head_data
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR  = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

    logic [PTR_BITS-1:0] r_head, n_head;
    logic [PTR_BITS-1:0] r_tail, n_tail;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                r_byp, n_byp;
    logic [WIDTH-1:0]    r_byp_data;
    logic [WIDTH-1:0]    ram_rd_data;

    // Pointer and count update
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_req.pop) begin
            n_head = (r_head == LAST_PTR) ? '0 : r_head + PTR_BITS'(1);
        end
        if (i_req.push) begin
            n_tail = (r_tail == LAST_PTR) ? '0 : r_tail + PTR_BITS'(1);
        end
        case ({i_req.push, i_req.pop})
            2'b10:   n_count = r_count + CNT_BITS'(1);
            2'b01:   n_count = r_count - CNT_BITS'(1);
            default: n_count = r_count;
        endcase
        // A write to the slot that becomes the head is not in the RAM read yet
        n_byp = i_req.push && (r_tail == n_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_byp   <= n_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_byp) begin
            r_byp_data <= i_push_data;
        end
    end

    fqs_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.push),
        .i_wr_addr (r_tail),
        .i_wr_data (i_push_data),
        .i_rd_addr (n_head),
        .o_rd_data (ram_rd_data)
    );

    assign o_head_data = r_byp ? r_byp_data : ram_rd_data;
    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == FULL_CNT);

endmodule

`default_nettype wire

@@ src/feedback_queue_scheduler.sv @@
`default_nettype none

// Three-level feedback queue CPU scheduler. Each transfer on i_in is either a
// process arrival (joins the tail of level one, or is refused and flagged as
// dropped when level one holds QUEUE_DEPTH entries) or one time tick, and each
// yields exactly one result on o_out. On a tick a free CPU takes the head of
// the highest non-empty level and loads that level's slice; the running
// process then executes one tick, finishing when its run time is used up, or
// in feedback mode requeuing one level lower (level three at its own tail)
// when its slice runs out, if that queue has room. One item is taken every
// cycle: the queue heads are held ready to pop, so all scheduling work fits
// between the state registers and a two-entry result buffer, and input ready
// falls only while that buffer holds two results. Configuration writes are
// always accepted and should be made only while the block is idle. Queue
// storage is a RAM per level and needs no clearing after reset.
module feedback_queue_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int TIME_BITS   = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fqs_in_if.sink    i_in,
    fqs_out_if.source o_out,
    fqs_cfg_if.sink   i_cfg
);

    localparam int ENTRY_BITS = ID_BITS + TIME_BITS;
    localparam int SB         = fqs_pkg::SLICE_BITS;

    typedef struct packed {
        logic               busy_res;
        logic [ID_BITS-1:0] running_id;
        logic               dispatched;
        logic               finished;
        logic               dropped;
    } t_result;

    // Configuration registers
    logic          r_mode;
    logic [SB-1:0] r_slice_one;
    logic [SB-1:0] r_slice_two;
    logic [SB-1:0] r_slice_three;

    // CPU state
    logic                            r_busy, n_busy;
    logic [ID_BITS-1:0]              r_cur_id, n_cur_id;
    logic [TIME_BITS-1:0]            r_cur_rem, n_cur_rem;
    logic [SB-1:0]                   r_slice_rem, n_slice_rem;
    logic [fqs_pkg::LEVEL_BITS-1:0]  r_cur_lvl, n_cur_lvl;

    // Level queues
    fqs_pkg::t_lvl_req lvl_req   [fqs_pkg::NUM_LEVELS];
    fqs_pkg::t_lvl_sts lvl_sts   [fqs_pkg::NUM_LEVELS];
    logic [ENTRY_BITS-1:0] lvl_wdata [fqs_pkg::NUM_LEVELS];
    logic [ENTRY_BITS-1:0] lvl_head  [fqs_pkg::NUM_LEVELS];

    // Result buffer
    t_result r_ob [2];
    logic    r_ob_wr_ptr;
    logic    r_ob_rd_ptr;
    logic [1:0] r_ob_cnt;

    logic    in_xfer;
    logic    out_xfer;
    t_result res;
    logic    pop_any;
    logic [fqs_pkg::LEVEL_BITS-1:0] pop_lvl;
    logic [fqs_pkg::LEVEL_BITS-1:0] target;
    logic    target_full;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;

    // Slice for a level, zero counts as one
    function automatic logic [SB-1:0] slice_of(
        input logic [fqs_pkg::LEVEL_BITS-1:0] lv,
        input logic [SB-1:0] s1,
        input logic [SB-1:0] s2,
        input logic [SB-1:0] s3
    );
        case (lv)
            fqs_pkg::LEVEL_ONE: slice_of = fqs_pkg::eff_slice(s1);
            fqs_pkg::LEVEL_TWO: slice_of = fqs_pkg::eff_slice(s2);
            default:            slice_of = fqs_pkg::eff_slice(s3);
        endcase
    endfunction

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= fqs_pkg::RST_FEEDBACK_MODE;
            r_slice_one   <= fqs_pkg::RST_SLICE_ONE;
            r_slice_two   <= fqs_pkg::RST_SLICE_TWO;
            r_slice_three <= fqs_pkg::RST_SLICE_THREE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                fqs_pkg::CFG_FEEDBACK_MODE: r_mode        <= i_cfg.data[0];
                fqs_pkg::CFG_SLICE_ONE:     r_slice_one   <= i_cfg.data;
                fqs_pkg::CFG_SLICE_TWO:     r_slice_two   <= i_cfg.data;
                fqs_pkg::CFG_SLICE_THREE:   r_slice_three <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Level queues
    for (genvar g = 0; g < fqs_pkg::NUM_LEVELS; g++) begin : g_level
        fqs_level #(
            .DEPTH (QUEUE_DEPTH),
            .WIDTH (ENTRY_BITS)
        ) u_level (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_req       (lvl_req[g]),
            .i_push_data (lvl_wdata[g]),
            .o_sts       (lvl_sts[g]),
            .o_head_data (lvl_head[g])
        );
    end

    // Scheduling decision for one item
    always_comb begin
        for (int l = 0; l < fqs_pkg::NUM_LEVELS; l++) begin
            lvl_req[l] = '0;
        end
        n_busy      = r_busy;
        n_cur_id    = r_cur_id;
        n_cur_rem   = r_cur_rem;
        n_slice_rem = r_slice_rem;
        n_cur_lvl   = r_cur_lvl;
        res         = '0;
        pop_any     = 1'b0;
        pop_lvl     = fqs_pkg::LEVEL_ONE;
        target      = fqs_pkg::LEVEL_THREE;
        target_full = 1'b0;

        // Highest non-empty level
        if (!lvl_sts[0].empty) begin
            pop_lvl = fqs_pkg::LEVEL_ONE;
        end else if (!lvl_sts[1].empty) begin
            pop_lvl = fqs_pkg::LEVEL_TWO;
        end else begin
            pop_lvl = fqs_pkg::LEVEL_THREE;
        end

        if (in_xfer) begin
            if (i_in.opcode == fqs_pkg::OP_ARRIVAL) begin
                if (lvl_sts[0].full) begin
                    res.dropped = 1'b1;
                end else begin
                    lvl_req[0].push = 1'b1;
                end
            end else begin
                // Dispatch onto a free CPU
                if (!r_busy && !(lvl_sts[0].empty && lvl_sts[1].empty && lvl_sts[2].empty)) begin
                    pop_any              = 1'b1;
                    lvl_req[pop_lvl].pop = 1'b1;
                    n_cur_id    = lvl_head[pop_lvl][ENTRY_BITS-1:TIME_BITS];
                    n_cur_rem   = lvl_head[pop_lvl][TIME_BITS-1:0];
                    n_cur_lvl   = pop_lvl;
                    n_slice_rem = slice_of(pop_lvl, r_slice_one, r_slice_two, r_slice_three);
                    n_busy      = 1'b1;
                    res.dispatched = 1'b1;
                end
                // Execute one tick
                if (n_busy) begin
                    res.busy_res   = 1'b1;
                    res.running_id = n_cur_id;
                    if (n_cur_rem <= TIME_BITS'(1)) begin
                        n_cur_rem    = '0;
                        n_busy       = 1'b0;
                        res.finished = 1'b1;
                    end else begin
                        n_cur_rem = n_cur_rem - TIME_BITS'(1);
                        if (r_mode) begin
                            if (n_slice_rem != '0) begin
                                n_slice_rem = n_slice_rem - SB'(1);
                            end
                            if (n_slice_rem == '0) begin
                                target = (n_cur_lvl == fqs_pkg::LEVEL_ONE) ?
                                         fqs_pkg::LEVEL_TWO : fqs_pkg::LEVEL_THREE;
                                target_full = lvl_sts[target].full &&
                                              !(pop_any && (pop_lvl == target));
                                if (!target_full) begin
                                    lvl_req[target].push = 1'b1;
                                    n_busy = 1'b0;
                                end else begin
                                    n_cur_lvl   = target;
                                    n_slice_rem = slice_of(target, r_slice_one,
                                                           r_slice_two, r_slice_three);
                                end
                            end
                        end
                    end
                end
            end
        end

        // Write data: arrivals into level one, demotions into the lower levels
        lvl_wdata[0] = {i_in.process_id, i_in.run_time};
        lvl_wdata[1] = {n_cur_id, n_cur_rem};
        lvl_wdata[2] = {n_cur_id, n_cur_rem};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cur_id    <= '0;
            r_cur_rem   <= '0;
            r_slice_rem <= '0;
            r_cur_lvl   <= fqs_pkg::LEVEL_ONE;
        end else begin
            r_busy      <= n_busy;
            r_cur_id    <= n_cur_id;
            r_cur_rem   <= n_cur_rem;
            r_slice_rem <= n_slice_rem;
            r_cur_lvl   <= n_cur_lvl;
        end
    end

    // Two-entry result buffer
    assign i_in.ready = (r_ob_cnt != 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr_ptr <= 1'b0;
            r_ob_rd_ptr <= 1'b0;
            r_ob_cnt    <= '0;
        end else begin
            if (in_xfer) begin
                r_ob_wr_ptr <= ~r_ob_wr_ptr;
            end
            if (out_xfer) begin
                r_ob_rd_ptr <= ~r_ob_rd_ptr;
            end
            case ({in_xfer, out_xfer})
                2'b10:   r_ob_cnt <= r_ob_cnt + 2'd1;
                2'b01:   r_ob_cnt <= r_ob_cnt - 2'd1;
                default: r_ob_cnt <= r_ob_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ob[r_ob_wr_ptr] <= res;
        end
    end

    assign o_out.valid      = (r_ob_cnt != '0);
    assign o_out.busy_res   = r_ob[r_ob_rd_ptr].busy_res;
    assign o_out.running_id = r_ob[r_ob_rd_ptr].running_id;
    assign o_out.dispatched = r_ob[r_ob_rd_ptr].dispatched;
    assign o_out.finished   = r_ob[r_ob_rd_ptr].finished;
    assign o_out.dropped    = r_ob[r_ob_rd_ptr].dropped;

    // A process holding the CPU always has at least one tick left
    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cur_rem != '0))
        else $error("running process with no remaining time");

    // At most one queue is popped per item, and never an empty one
    a_single_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({lvl_req[2].pop, lvl_req[1].pop, lvl_req[0].pop}) &&
        !(lvl_req[0].pop && lvl_sts[0].empty) &&
        !(lvl_req[1].pop && lvl_sts[1].empty) &&
        !(lvl_req[2].pop && lvl_sts[2].empty))
        else $error("illegal level queue pop");

    // A dispatch only happens on a free CPU during a tick
    a_dispatch_free_cpu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && res.dispatched) |-> (!r_busy && i_in.opcode == fqs_pkg::OP_TICK))
        else $error("dispatch while CPU occupied");

    // A pushed demotion never lands in a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!lvl_req[1].push || !lvl_sts[1].full) &&
        (!lvl_req[2].push || !lvl_sts[2].full || lvl_req[2].pop))
        else $error("push into a full level queue");

endmodule

`default_nettype wire

@@ bench/feedback_queue_scheduler_tb.sv @@
module feedback_queue_scheduler_tb;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int TIME_BITS   = 16;

    // One queued process: id and ticks still owed
    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] rem;
    } t_proc;

    typedef struct {
        fqs_pkg::t_opcode     op;
        logic [ID_BITS-1:0]   pid;
        logic [TIME_BITS-1:0] rt;
    } t_job_item;

    typedef struct {
        logic               busy;
        logic [ID_BITS-1:0] rid;
        logic               disp;
        logic               fin;
        logic               drop;
    } t_sched_result;

    logic i_clk;
    logic i_rst_n;

    fqs_in_if  #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) in_bus ();
    fqs_out_if #(.ID_BITS(ID_BITS))                        out_bus ();
    fqs_cfg_if                                             cfg_bus ();

    feedback_queue_scheduler #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // Scheduler state as the bench sees it
    t_proc       lvl_q [fqs_pkg::NUM_LEVELS][$];
    logic        cpu_busy;
    t_proc       cur;
    int          cur_level;
    int          slice_left;
    logic        fb_mode;
    logic [7:0]  slice_cfg [fqs_pkg::NUM_LEVELS];

    t_job_item     job_backlog [$];
    t_sched_result due_results [$];
    t_job_item     offered;
    t_sched_result want;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   fail_count    = 0;
    logic stall_armed   = 1'b0;
    logic stall_hold    = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    function automatic int slice_of(int lv);
        return (slice_cfg[lv] == 8'd0) ? 1 : int'(slice_cfg[lv]);
    endfunction

    // Work out the result of one item and advance the scheduler state
    function automatic t_sched_result predict_schedule(t_job_item it);
        t_sched_result r;
        int target;
        r = '{busy: 1'b0, rid: '0, disp: 1'b0, fin: 1'b0, drop: 1'b0};
        if (it.op == fqs_pkg::OP_ARRIVAL) begin
            if (lvl_q[0].size() >= QUEUE_DEPTH)
                r.drop = 1'b1;
            else
                lvl_q[0].push_back('{id: it.pid, rem: it.rt});
        end else begin
            // free CPU takes the head of the highest non-empty level
            if (!cpu_busy) begin
                for (int lv = 0; lv < fqs_pkg::NUM_LEVELS; lv++) begin
                    if (!cpu_busy && lvl_q[lv].size() > 0) begin
                        cur        = lvl_q[lv].pop_front();
                        cur_level  = lv;
                        slice_left = slice_of(lv);
                        cpu_busy   = 1'b1;
                        r.disp     = 1'b1;
                    end
                end
            end
            if (cpu_busy) begin
                r.busy = 1'b1;
                r.rid  = cur.id;
                if (cur.rem <= 1) begin
                    cur.rem  = '0;
                    cpu_busy = 1'b0;
                    r.fin    = 1'b1;
                end else begin
                    cur.rem--;
                    if (fb_mode) begin
                        if (slice_left > 0)
                            slice_left--;
                        // slice used up: demote, or keep the CPU if the target is full
                        if (slice_left == 0) begin
                            target = (cur_level >= 2) ? 2 : cur_level + 1;
                            if (lvl_q[target].size() < QUEUE_DEPTH) begin
                                lvl_q[target].push_back(cur);
                                cpu_busy = 1'b0;
                            end else begin
                                cur_level  = target;
                                slice_left = slice_of(target);
                            end
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // Input driver: predicts on each transfer, then offers the next item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                due_results.push_back(predict_schedule(offered));
            if (!in_bus.valid || in_bus.ready) begin
                if (job_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered           = job_backlog.pop_front();
                    in_bus.valid      <= 1'b1;
                    in_bus.opcode     <= offered.op;
                    in_bus.process_id <= offered.pid;
                    in_bus.run_time   <= offered.rt;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (out_bus.busy_res !== want.busy) begin
                        $error("busy_res: expected %0d, got %0d", want.busy, out_bus.busy_res);
                        fail_count++;
                    end
                    if (out_bus.running_id !== want.rid) begin
                        $error("running_id: expected %h, got %h", want.rid, out_bus.running_id);
                        fail_count++;
                    end
                    if (out_bus.dispatched !== want.disp) begin
                        $error("dispatched: expected %0d, got %0d", want.disp,
                               out_bus.dispatched);
                        fail_count++;
                    end
                    if (out_bus.finished !== want.fin) begin
                        $error("finished: expected %0d, got %0d", want.fin, out_bus.finished);
                        fail_count++;
                    end
                    if (out_bus.dropped !== want.drop) begin
                        $error("dropped: expected %0d, got %0d", want.drop, out_bus.dropped);
                        fail_count++;
                    end
                end
            end
            out_bus.ready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off so the result buffer fills and input ready drops
    initial begin
        wait (stall_armed);
        @(posedge i_clk);
        stall_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        stall_hold <= 1'b0;
    end

    task automatic push_job(fqs_pkg::t_opcode op, logic [ID_BITS-1:0] pid,
                            logic [TIME_BITS-1:0] rt);
        job_backlog.push_back('{op: op, pid: pid, rt: rt});
    endtask

    function automatic logic [TIME_BITS-1:0] pick_run_time();
        int sel;
        sel = $urandom_range(31);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        else if (sel == 2)
            return TIME_BITS'($urandom);
        else if (sel < 8)
            return TIME_BITS'($urandom_range(3, 1));
        else
            return TIME_BITS'($urandom_range(40, 1));
    endfunction

    // Random bursts of arrivals and ticks, plus floods that fill the first level
    task automatic queue_random(int n);
        int queued;
        int kind;
        int len;
        queued = 0;
        while (queued < n) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(20, 1) : $urandom_range(5, 1);
                for (int k = 0; k < len; k++)
                    push_job(fqs_pkg::OP_ARRIVAL, ID_BITS'($urandom), pick_run_time());
                queued += len;
            end else if (kind < 8) begin
                len = $urandom_range(24, 1);
                for (int k = 0; k < len; k++)
                    push_job(fqs_pkg::OP_TICK, ID_BITS'($urandom), TIME_BITS'($urandom));
                queued += len;
            end else begin
                // fill level one, churn it into level two, then refill behind it
                for (int rep = 0; rep < 2; rep++) begin
                    for (int k = 0; k < QUEUE_DEPTH + 1; k++)
                        push_job(fqs_pkg::OP_ARRIVAL, ID_BITS'($urandom),
                                 TIME_BITS'($urandom_range(60, 8)));
                    for (int k = 0; k < 20; k++)
                        push_job(fqs_pkg::OP_TICK, ID_BITS'($urandom), TIME_BITS'($urandom));
                end
                queued += 2 * (QUEUE_DEPTH + 21);
            end
        end
    endtask

    // Wait until every offered item has its result back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (job_backlog.size() != 0 || in_bus.valid || due_results.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(fqs_pkg::t_cfg_index idx, logic [fqs_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            fqs_pkg::CFG_FEEDBACK_MODE: fb_mode      = val[0];
            fqs_pkg::CFG_SLICE_ONE:     slice_cfg[0] = val;
            fqs_pkg::CFG_SLICE_TWO:     slice_cfg[1] = val;
            fqs_pkg::CFG_SLICE_THREE:   slice_cfg[2] = val;
            default: ;
        endcase
    endtask

    // One phase: reprogram while idle, then run random traffic
    task automatic run_phase(logic mode, logic [7:0] s1, logic [7:0] s2, logic [7:0] s3,
                             int send_pct, int recv_pct, logic pressure);
        wait_drained();
        write_reg(fqs_pkg::CFG_FEEDBACK_MODE, {7'd0, mode});
        write_reg(fqs_pkg::CFG_SLICE_ONE, s1);
        write_reg(fqs_pkg::CFG_SLICE_TWO, s2);
        write_reg(fqs_pkg::CFG_SLICE_THREE, s3);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random(118);
        if (pressure)
            stall_armed = 1'b1;
    endtask

    // Stimulus
    initial begin
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.opcode     = fqs_pkg::OP_TICK;
        in_bus.process_id = '0;
        in_bus.run_time   = '0;
        out_bus.ready     = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = fqs_pkg::CFG_FEEDBACK_MODE;
        cfg_bus.data      = '0;
        cpu_busy          = 1'b0;
        cur               = '0;
        cur_level         = 0;
        slice_left        = 0;
        fb_mode           = fqs_pkg::RST_FEEDBACK_MODE;
        slice_cfg[0]      = fqs_pkg::RST_SLICE_ONE;
        slice_cfg[1]      = fqs_pkg::RST_SLICE_TWO;
        slice_cfg[2]      = fqs_pkg::RST_SLICE_THREE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick, zero and unit run time, demotion through all levels
        @(negedge i_clk);
        send_idle_pct = 13;
        recv_idle_pct = 59;
        push_job(fqs_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        push_job(fqs_pkg::OP_ARRIVAL, 16'hFFFF, 16'd0);
        push_job(fqs_pkg::OP_TICK, 16'h0000, 16'h0000);
        push_job(fqs_pkg::OP_ARRIVAL, 16'h0000, 16'd1);
        push_job(fqs_pkg::OP_TICK, 16'h1234, 16'h4321);
        push_job(fqs_pkg::OP_ARRIVAL, 16'hA5A5, 16'hFFFF);
        push_job(fqs_pkg::OP_ARRIVAL, 16'h5A5A, 16'd3);
        for (int k = 0; k < 11; k++)
            push_job(fqs_pkg::OP_TICK, 16'h0000, 16'h0000);
        push_job(fqs_pkg::OP_ARRIVAL, 16'h8001, 16'h8000);
        push_job(fqs_pkg::OP_TICK, 16'hFFFF, 16'h0000);
        push_job(fqs_pkg::OP_TICK, 16'h0000, 16'hFFFF);

        // feedback and run-to-completion settings, with leftovers across mode changes
        run_phase(1'b1, 8'd1,   8'd1,   8'd1,   13, 59, 1'b0);
        run_phase(1'b0, 8'd7,   8'd3,   8'd9,   13, 59, 1'b0);
        run_phase(1'b1, 8'd255, 8'd255, 8'd255, 13, 59, 1'b0);
        run_phase(1'b1, 8'd0,   8'd0,   8'd0,   59, 13, 1'b0);
        run_phase(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 59, 13, 1'b0);
        run_phase(1'b1, 8'($urandom_range(8)), 8'($urandom_range(8)), 8'($urandom_range(8)),
                  59, 13, 1'b0);
        run_phase(1'b1, fqs_pkg::RST_SLICE_ONE, fqs_pkg::RST_SLICE_TWO,
                  fqs_pkg::RST_SLICE_THREE, 0, 0, 1'b1);
        run_phase(1'b0, 8'd1, 8'd255, 8'd0, 0, 0, 1'b0);
        run_phase(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 0, 0, 1'b0);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ feedback_queue_scheduler.f @@
src/fqs_pkg.sv
src/fqs_if.sv
src/fqs_ram.sv
src/fqs_level.sv
src/feedback_queue_scheduler.sv
bench/feedback_queue_scheduler_tb.sv
